// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, constants and decode helpers for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TickW     = 10;
    localparam int PhaseW    = 5;
    localparam int ByteW     = 8;
    localparam int FifoDepth = 2;
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    localparam logic [TickW-1:0] TicksReset = 10'd8;

    // register index taken from paddr[2]
    localparam logic RegTicksPerPhase = 1'b0;

    localparam logic [PhaseW-1:0] WriteBitSteps = 5'd24;
    localparam logic [PhaseW-1:0] WriteRelStep  = 5'd26;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5
    } cmd_t;

    // one tick after classification
    typedef struct packed {
        cmd_t             cmd;        // CMD_NONE when no command comes with the tick
        logic [ByteW-1:0] load_data;  // initial shift register contents
        logic             sda_in;
    } tick_t;

    typedef struct packed {
        logic             rejected;
        logic             ack_seen;
        logic [ByteW-1:0] rx_byte;
        logic             done_res;
        logic             busy_res;
        logic             sda_drive;
        logic             sda_level;
        logic             scl_level;
    } result_t;

    function automatic logic [PhaseW-1:0] phase_total(input cmd_t cmd);
        logic [PhaseW-1:0] r;
        unique case (cmd)
            CMD_START: r = 5'd4;
            CMD_STOP:  r = 5'd3;
            CMD_WRITE: r = 5'd28;
            CMD_READ:  r = 5'd25;
            CMD_ACK:   r = 5'd4;
            default:   r = 5'd1;
        endcase
        return r;
    endfunction

    // small constant table: step position within a three-step bit slot
    function automatic logic [1:0] mod3(input logic [PhaseW-1:0] v);
        logic [1:0] r;
        r = 2'd0;
        for (int i = 0; i < (1 << PhaseW); i++) begin
            if (v == PhaseW'(i)) r = 2'(i % 3);
        end
        return r;
    endfunction

endpackage

// File: sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Classifies each incoming tick: command decode and shift register preload.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic [2:0]                     mode,
    input  logic [i2cm_pkg::ByteW-1:0]     tx_byte,
    input  logic                           ack_to_send,
    input  logic                           sda_in,
    output i2cm_pkg::tick_t                tick
);
    import i2cm_pkg::*;

    cmd_t cmd;

    always_comb begin
        unique case (mode)
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ, CMD_ACK: cmd = cmd_t'(mode);
            default: cmd = CMD_NONE;  // codes six and seven act as no command
        endcase
    end

    always_comb begin
        tick.cmd    = cmd;
        tick.sda_in = sda_in;
        case (cmd)
            CMD_WRITE: tick.load_data = tx_byte;
            CMD_ACK:   tick.load_data = {{(ByteW-1){1'b0}}, ack_to_send};
            default:   tick.load_data = '0;
        endcase
    end

endmodule

// File: sv/i2cm_fifo.sv
// ----------------------------------------------------------------------------
// i2cm_fifo
// Short request queue between the classifier and the bit sequencer.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg,  count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != FullCnt);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: sv/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Bit sequencer: phase timing, SCL/SDA control, shift register and the
// registered result stage.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [i2cm_pkg::TickW-1:0]   ticks_per_phase,
    input  logic                         tick_valid,
    output logic                         tick_ready,
    input  i2cm_pkg::tick_t              tick,
    output logic                         res_valid,
    input  logic                         res_ready,
    output i2cm_pkg::result_t            res
);
    import i2cm_pkg::*;

    cmd_t               cmd_reg,   cmd_next;
    logic [PhaseW-1:0]  step_reg,  step_next;
    logic [TickW-1:0]   tick_reg,  tick_next;
    logic [ByteW-1:0]   shift_reg, shift_next;
    logic               scl_reg,   scl_next;
    logic               sda_reg,   sda_next;
    logic               en_reg,    en_next;
    logic               ack_reg,   ack_next;
    logic               valid_reg;
    result_t            res_reg,   res_next;

    logic [TickW-1:0]   limit;
    logic [TickW-1:0]   tick_inc;
    logic [PhaseW-1:0]  step_inc;
    logic [PhaseW-1:0]  rd_k;
    logic               run;
    logic               fire;

    assign tick_ready = !valid_reg || res_ready;
    assign fire       = tick_valid && tick_ready;
    assign res_valid  = valid_reg;
    assign res        = res_reg;

    assign limit    = (ticks_per_phase == '0) ? TickW'(1) : ticks_per_phase;
    assign tick_inc = tick_reg + 1'b1;
    assign step_inc = step_reg + 1'b1;

    always_comb begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        en_next    = en_reg;
        ack_next   = ack_reg;
        run        = 1'b0;
        rd_k       = '0;
        res_next   = '0;

        if (cmd_reg != CMD_NONE) begin
            res_next.rejected = (tick.cmd != CMD_NONE);
            if (tick_inc >= limit) begin
                tick_next = '0;
                if (step_inc >= phase_total(cmd_reg)) begin
                    res_next.done_res = 1'b1;
                    if (cmd_reg == CMD_READ) begin
                        res_next.rx_byte = shift_reg;
                        en_next          = 1'b1;
                    end else if (cmd_reg == CMD_WRITE) begin
                        res_next.ack_seen = ack_reg;
                        en_next           = 1'b1;
                    end
                    cmd_next  = CMD_NONE;
                    step_next = '0;
                end else begin
                    step_next = step_inc;
                    run       = 1'b1;
                end
            end else begin
                tick_next = tick_inc;
            end
        end else if (tick.cmd != CMD_NONE) begin
            cmd_next   = tick.cmd;
            step_next  = '0;
            tick_next  = '0;
            shift_next = tick.load_data;
            run        = 1'b1;
        end

        // line action at the first tick of a phase
        if (run) begin
            unique case (cmd_next)
                CMD_START: begin
                    if (step_next == 5'd0)      scl_next = 1'b1;
                    else if (step_next == 5'd1) sda_next = 1'b1;
                    else if (step_next == 5'd2) sda_next = 1'b0;
                    else                        scl_next = 1'b0;
                end
                CMD_STOP: begin
                    if (step_next == 5'd0)      sda_next = 1'b0;
                    else if (step_next == 5'd1) scl_next = 1'b1;
                    else                        sda_next = 1'b1;
                end
                CMD_WRITE: begin
                    if (step_next < WriteBitSteps) begin
                        case (mod3(step_next))
                            2'd0: scl_next = 1'b0;
                            2'd1: begin
                                sda_next   = shift_next[ByteW-1];
                                shift_next = {shift_next[ByteW-2:0], 1'b0};
                            end
                            default: scl_next = 1'b1;
                        endcase
                    end else if (step_next < WriteRelStep) begin
                        scl_next = 1'b0;
                    end else if (step_next == WriteRelStep) begin
                        en_next  = 1'b0;  // let the slave drive the ack bit
                        scl_next = 1'b1;
                    end else begin
                        ack_next = tick.sda_in;
                        scl_next = 1'b0;
                    end
                end
                CMD_READ: begin
                    if (step_next == 5'd0) begin
                        scl_next = 1'b0;
                    end else begin
                        rd_k = step_next - 1'b1;
                        case (mod3(rd_k))
                            2'd0: begin
                                if (rd_k == '0) en_next = 1'b0;
                                scl_next = 1'b1;
                            end
                            2'd1: shift_next = {shift_next[ByteW-2:0], tick.sda_in};
                            default: scl_next = 1'b0;
                        endcase
                    end
                end
                CMD_ACK: begin
                    if (step_next == 5'd0)      scl_next = 1'b0;
                    else if (step_next == 5'd1) sda_next = shift_next[0];
                    else if (step_next == 5'd2) scl_next = 1'b1;
                    else                        scl_next = 1'b0;
                end
                default: ;
            endcase
        end

        res_next.scl_level = scl_next;
        res_next.sda_level = sda_next;
        res_next.sda_drive = en_next;
        res_next.busy_res  = (cmd_next != CMD_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_NONE;
            step_reg  <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            en_reg    <= 1'b1;
            ack_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                cmd_reg   <= cmd_next;
                step_reg  <= step_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                en_reg    <= en_next;
                ack_reg   <= ack_next;
                valid_reg <= 1'b1;
            end else if (res_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) res_reg <= res_next;
    end

endmodule

// File: sv/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Tick-driven I2C master bit engine with an APB register for phase length.
// ----------------------------------------------------------------------------
// Every request on the s_ channel is one time tick: it carries the sampled SDA
// level and optionally a command (start, stop, write byte, read byte, send ack).
// Every tick yields exactly one result on the m_ channel with the SCL/SDA pin
// controls, busy, done, the received byte and the acknowledge seen. A command
// that arrives while busy is dropped and flagged as rejected.
// A tick accepted on the s_ channel passes through the queue and the registered
// result stage before it shows on m_tvalid; with m_tready high one tick is
// taken per cycle.
// A two-entry queue sits between the classifier and the sequencer, and the
// result register accepts a new value in the cycle it is taken, so a stalled
// receiver holds the result and backs up the queue before s_tready drops.
// ticks_per_phase sits at byte address 0 (reset 8, zero acts as one); write it
// only while no command is in progress.
// Reset (aresetn low, synchronous) idles the sequencer with SCL and SDA driven
// high and empties the queue and the result register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
    parameter int FIFO_DEPTH = i2cm_pkg::FifoDepth
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // apb register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2cm_pkg::AddrW-1:0]  paddr,
    input  logic [i2cm_pkg::DataW-1:0]  pwdata,
    output logic [i2cm_pkg::DataW-1:0]  prdata,
    output logic                        pready,
    // tick requests
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,  // tx_byte[7:0], ack_to_send, sda_in, zero pad
    input  logic [2:0]                  s_tuser,  // mode
    // results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata   // scl_level, sda_level, sda_drive, busy_res,
                                                  // done_res, rx_byte[7:0], ack_seen, rejected,
                                                  // zero pad
);
    import i2cm_pkg::*;

    logic [TickW-1:0] tpp_reg;
    logic             reg_idx;
    tick_t            tick_in, tick_q;
    logic             q_valid, q_ready;
    result_t          res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign prdata  = (reg_idx == RegTicksPerPhase) ? {{(DataW-TickW){1'b0}}, tpp_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpp_reg <= TicksReset;
        end else if (psel && penable && pwrite && pready && reg_idx == RegTicksPerPhase) begin
            tpp_reg <= pwdata[TickW-1:0];
        end
    end

    i2cm_front u_front (
        .mode        (s_tuser),
        .tx_byte     (s_tdata[7:0]),
        .ack_to_send (s_tdata[8]),
        .sda_in      (s_tdata[9]),
        .tick        (tick_in)
    );

    i2cm_fifo #(
        .WIDTH ($bits(tick_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (tick_in),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (tick_q)
    );

    i2cm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ticks_per_phase (tpp_reg),
        .tick_valid      (q_valid),
        .tick_ready      (q_ready),
        .tick            (tick_q),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res             (res)
    );

    assign m_tdata = {1'b0, res};

endmodule

// File: sv/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result stream of the I2C master bit engine.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // m_tdata: [0] scl, [1] sda, [2] drive, [3] busy, [4] done, [12:5] rx,
    // [13] ack_seen, [14] rejected

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a finishing command leaves the engine idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
        else $error("done and busy together");

    a_data_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[12:5] != 8'd0 || m_tdata[13]) |-> m_tdata[4])
        else $error("rx byte or ack seen outside a done result");

    // rejection only happens while a command is in flight
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[3] || m_tdata[4])
        else $error("rejected while idle");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/i2c_master_bit_engine_chk.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_chk
// Watches the register port and both streams of the I2C master bit engine,
// predicts the pin controls and status of every tick, and compares the
// results in order. The running failure count goes back to the testbench top.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_chk
    import i2cm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    input  logic [DataW-1:0] prdata,
    input  logic             pready,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [15:0]      s_tdata,
    input  logic [2:0]       s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [15:0]      m_tdata,
    output int               pending,
    output int               fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TickW-1:0] ResetPhaseLen = 10'd8;

    // predicted engine state
    logic [TickW-1:0]  phase_len;
    cmd_t              cur_cmd;
    logic [PhaseW-1:0] step;
    logic [TickW-1:0]  tick_cnt;
    logic [7:0]        shreg;
    logic              scl_q;
    logic              sda_q;
    logic              drive_q;
    logic              ack_q;

    result_t due_results[$];
    int      mismatches = 0;

    assign fail_count = mismatches + pending;

    function automatic int phases_of(input cmd_t c);
        case (c)
            CMD_START: return 4;
            CMD_STOP:  return 3;
            CMD_WRITE: return 28;
            CMD_READ:  return 25;
            CMD_ACK:   return 4;
            default:   return 1;
        endcase
    endfunction

    // pin action at the first tick of a phase
    task automatic enter_phase(input logic sda_i);
        int s;
        int k;
        s = int'(step);
        case (cur_cmd)
            CMD_START: begin
                if (s == 0) scl_q = 1'b1;
                else if (s == 1) sda_q = 1'b1;
                else if (s == 2) sda_q = 1'b0;
                else scl_q = 1'b0;
            end
            CMD_STOP: begin
                if (s == 0) sda_q = 1'b0;
                else if (s == 1) scl_q = 1'b1;
                else sda_q = 1'b1;
            end
            CMD_WRITE: begin
                if (s < 24) begin
                    case (s % 3)
                        0: scl_q = 1'b0;
                        1: begin
                            sda_q = shreg[7];
                            shreg = {shreg[6:0], 1'b0};
                        end
                        default: scl_q = 1'b1;
                    endcase
                end else if (s == 24 || s == 25) begin
                    scl_q = 1'b0;
                end else if (s == 26) begin
                    drive_q = 1'b0;
                    scl_q   = 1'b1;
                end else begin
                    ack_q = sda_i;
                    scl_q = 1'b0;
                end
            end
            CMD_READ: begin
                if (s == 0) begin
                    scl_q = 1'b0;
                end else begin
                    k = s - 1;
                    case (k % 3)
                        0: begin
                            if (k == 0) drive_q = 1'b0;
                            scl_q = 1'b1;
                        end
                        1: shreg = {shreg[6:0], sda_i};
                        default: scl_q = 1'b0;
                    endcase
                end
            end
            CMD_ACK: begin
                if (s == 0) scl_q = 1'b0;
                else if (s == 1) sda_q = shreg[0];
                else if (s == 2) scl_q = 1'b1;
                else scl_q = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic advance_sequencer(input logic [2:0] mode, input logic [7:0] tx,
                                     input logic ackb, input logic sda_i,
                                     output result_t r);
        logic             is_cmd;
        logic [TickW-1:0] lim;
        is_cmd = (mode >= CMD_START) && (mode <= CMD_ACK);
        lim    = (phase_len == '0) ? TickW'(1) : phase_len;
        r      = '0;
        if (cur_cmd != CMD_NONE) begin
            r.rejected = is_cmd;
            tick_cnt   = tick_cnt + 1'b1;
            if (tick_cnt >= lim) begin
                tick_cnt = '0;
                step     = step + 1'b1;
                if (step >= phases_of(cur_cmd)) begin
                    r.done_res = 1'b1;
                    if (cur_cmd == CMD_READ) begin
                        r.rx_byte = shreg;
                        drive_q   = 1'b1;
                    end else if (cur_cmd == CMD_WRITE) begin
                        r.ack_seen = ack_q;
                        drive_q    = 1'b1;
                    end
                    cur_cmd = CMD_NONE;
                    step    = '0;
                end else begin
                    enter_phase(sda_i);
                end
            end
        end else if (is_cmd) begin
            cur_cmd  = cmd_t'(mode);
            step     = '0;
            tick_cnt = '0;
            if (mode == CMD_ACK) shreg = {7'b0, ackb};
            else if (mode == CMD_WRITE) shreg = tx;
            else shreg = 8'h00;
            enter_phase(sda_i);
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = drive_q;
        r.busy_res  = (cur_cmd != CMD_NONE);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t predicted;
        result_t want;
        result_t got;
        if (!aresetn) begin
            phase_len = ResetPhaseLen;
            cur_cmd   = CMD_NONE;
            step      = '0;
            tick_cnt  = '0;
            shreg     = '0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            drive_q   = 1'b1;
            ack_q     = 1'b0;
            due_results.delete();
        end else begin
            // only register 0 exists, other indexes are ignored
            if (psel && penable && pready && paddr[AddrW-1:2] == '0) begin
                if (pwrite) phase_len = pwdata[TickW-1:0];
                else check_field("prdata", {{(DataW-TickW){1'b0}}, phase_len}, prdata);
            end
            if (s_tvalid && s_tready) begin
                advance_sequencer(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9], predicted);
                due_results.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[14:0]);
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %0h with no request outstanding",
                                 $realtime, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("scl_level", 32'(want.scl_level), 32'(got.scl_level));
                    check_field("sda_level", 32'(want.sda_level), 32'(got.sda_level));
                    check_field("sda_drive", 32'(want.sda_drive), 32'(got.sda_drive));
                    check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(got.done_res));
                    check_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
                    check_field("ack_seen", 32'(want.ack_seen), 32'(got.ack_seen));
                    check_field("rejected", 32'(want.rejected), 32'(got.rejected));
                    check_field("pad", 32'h0, 32'(m_tdata[15]));
                end
            end
        end
        pending <= due_results.size();
    end

endmodule

// File: bench/i2c_master_bit_engine_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Drives time ticks and commands into the I2C master bit engine: a directed
// pass over every command and corner, then random commands and noise under
// several short phase lengths (zero among them), with random gaps and stalls
// on both streams. The checker beside the block predicts each result.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam logic [AddrW-1:0] RegPhaseLen = 3'd0;
    localparam logic [AddrW-1:0] UnusedAddr  = 3'd4;

    // where a command is thrown at the engine while it is busy
    localparam int NoIntrude   = 0;
    localparam int MidIntrude  = 1;
    localparam int EdgeIntrude = 2;

    // sda level applied on the ticks of one command
    localparam int SdaLow  = 0;
    localparam int SdaHigh = 1;
    localparam int SdaRand = 2;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             psel     = 1'b0;
    logic             penable  = 1'b0;
    logic             pwrite   = 1'b0;
    logic [AddrW-1:0] paddr    = '0;
    logic [DataW-1:0] pwdata   = '0;
    logic [DataW-1:0] prdata;
    logic             pready;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata  = '0;
    logic [2:0]       s_tuser  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;

    int pending;
    int fail_count;

    bit calm       = 1'b0;
    int lim        = 8;
    int ticks      = 0;
    int commands   = 0;
    int intrusions = 0;
    int settings   = 0;

    always #6 aclk = ~aclk;

    i2c_master_bit_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    i2c_master_bit_engine_chk chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 25);
    end

    function automatic int cmd_len(input cmd_t c);
        case (c)
            CMD_START: return 4;
            CMD_STOP:  return 3;
            CMD_WRITE: return 28;
            CMD_READ:  return 25;
            default:   return 4;
        endcase
    endfunction

    function automatic logic pick_sda(input int sel);
        if (sel == SdaLow) return 1'b0;
        if (sel == SdaHigh) return 1'b1;
        return 1'($urandom());
    endfunction

    function automatic int pick_intrude();
        int r;
        r = $urandom_range(9);
        if (r == 0) return EdgeIntrude;
        if (r == 1) return MidIntrude;
        return NoIntrude;
    endfunction

    // entered just after a falling edge, returns just after one
    task automatic send_tick(input logic [2:0] mode, input logic [7:0] tx,
                             input logic ackb, input logic sda);
        while (!calm && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, sda, ackb, tx};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        ticks++;
        @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                              input logic [DataW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // waits for the engine to drain, then changes the phase length
    task automatic set_phase_len(input logic [TickW-1:0] val);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        apb_access(1'b1, RegPhaseLen, ($urandom() & 32'hFFFF_FC00) | DataW'(val));
        apb_access(1'b0, RegPhaseLen, '0);
        lim = (val == '0) ? 1 : int'(val);
        settings++;
    endtask

    // one command, then ticks with no command (bar an optional intruding one) until it completes and a little beyond
    task automatic run_command(input cmd_t c, input logic [7:0] tx, input logic ackb,
                               input int sda_sel, input int intrude);
        int         span;
        int         spot;
        logic [2:0] m;
        span = cmd_len(c) * lim;
        spot = (intrude == EdgeIntrude) ? span :
               (intrude == MidIntrude) ? $urandom_range(span, 1) : 0;
        send_tick(c, tx, ackb, pick_sda(sda_sel));
        commands++;
        for (int i = 1; i <= span + $urandom_range(2); i++) begin
            if (i == spot) begin
                m = 3'($urandom_range(CMD_ACK, CMD_START));
                intrusions++;
            end else if ($urandom_range(15) == 0) begin
                m = 3'($urandom_range(7, 6));
            end else begin
                m = CMD_NONE;
            end
            send_tick(m, 8'($urandom()), 1'($urandom()), pick_sda(sda_sel));
        end
    endtask

    task automatic rand_command(input cmd_t c);
        run_command(c, 8'($urandom()), 1'($urandom()), SdaRand, pick_intrude());
    endtask

    // random single commands and noise ticks until the tick budget is spent
    task automatic exercise(input logic [TickW-1:0] val, input int target);
        int first;
        set_phase_len(val);
        first = ticks;
        while (ticks - first < target) begin
            if ($urandom_range(3) == 0) begin
                send_tick(3'($urandom_range(7, 6)), 8'($urandom()), 1'($urandom()),
                          1'($urandom()));
            end else begin
                rand_command(cmd_t'($urandom_range(CMD_ACK, CMD_START)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of the phase length, and one command at it
        apb_access(1'b0, RegPhaseLen, '0);
        run_command(CMD_START, 8'h00, 1'b0, SdaRand, NoIntrude);

        // directed pass with one tick per phase
        set_phase_len(10'd1);
        run_command(CMD_WRITE, 8'h00, 1'b0, SdaLow, NoIntrude);
        run_command(CMD_WRITE, 8'hFF, 1'b1, SdaHigh, NoIntrude);
        run_command(CMD_READ, 8'hFF, 1'b1, SdaHigh, NoIntrude);
        run_command(CMD_READ, 8'h00, 1'b0, SdaLow, NoIntrude);
        run_command(CMD_ACK, 8'h00, 1'b0, SdaRand, NoIntrude);
        run_command(CMD_ACK, 8'hFF, 1'b1, SdaRand, NoIntrude);
        run_command(CMD_STOP, 8'h00, 1'b0, SdaRand, NoIntrude);
        send_tick(3'd6, 8'hFF, 1'b1, 1'b1);
        send_tick(3'd7, 8'h00, 1'b0, 1'b0);
        // commands thrown in while busy, also on the completing tick
        run_command(CMD_START, 8'h3C, 1'b1, SdaRand, MidIntrude);
        run_command(CMD_WRITE, 8'h5A, 1'b0, SdaRand, EdgeIntrude);
        run_command(CMD_READ, 8'hC3, 1'b1, SdaRand, MidIntrude);
        run_command(CMD_ACK, 8'h00, 1'b1, SdaRand, EdgeIntrude);
        run_command(CMD_STOP, 8'h00, 1'b0, SdaRand, EdgeIntrude);

        // a write to an unmapped address must leave the phase length alone
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        apb_access(1'b1, UnusedAddr, 32'h0000_0001);
        apb_access(1'b0, RegPhaseLen, '0);

        exercise(10'd0, 40);
        calm = 1'b1;
        exercise(10'd2, 35);
        calm = 1'b0;
        exercise(10'd3, 25);

        // longest phase length, written and read back
        set_phase_len(10'd1023);

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered %0d ticks, %0d commands and %0d commands sent while busy",
                 ticks, commands, intrusions);
        $display("over %0d phase-length settings, with 1023 written and read back",
                 settings + 1);
        if (fail_count == 0) begin
            $display("i2c_master_bit_engine_tb: PASS");
        end else begin
            $display("i2c_master_bit_engine_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(25_000_000);
        $display("timeout with %0d results outstanding", pending);
        $display("i2c_master_bit_engine_tb: FAIL");
        $finish;
    end

endmodule
